### rtl/sha256_byte_stream_hasher_assert.svh
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// expression must never hold
`define SHB_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SHB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/shb_pkg.sv
// Package: types, codes, constants and round functions of the SHA-256 hasher.
package shb_pkg;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_START  = 6'd56;
	localparam logic [5:0] LAST_BYTE  = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD  = 3'd7;

	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] r;
		unique case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] r;
		unique case (idx)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

### rtl/shb_if.sv
// Stream interfaces of the hasher: input byte channel and digest word channel.
interface shb_in_if;
	import shb_pkg::*;
	logic       valid;
	logic       ready;
	op_t        operation;
	logic [7:0] data_byte;
	modport source (output valid, output operation, output data_byte, input ready);
	modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface shb_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink   (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

### rtl/shb_ram.sv
// Generic simple dual-port RAM with registered read.
module shb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: one byte per absorb transfer, eight digest words on finish.
// Absorb transfers are taken one per cycle while the 64-byte block fills; the 64th byte
// starts the compression, which holds off input through a load step, 64 rounds at one
// round per cycle and a fold into the chaining words, so no byte is taken while a block is
// being compressed. A finish transfer writes the padding and the big-endian bit count into
// the block one byte per cycle (when the 0x80 mark lands past byte 55 the rest of that
// block is padded and compressed, and a further block is filled with padding and the
// length), compresses, then presents the eight digest words, most significant first, one
// per output transfer.
// Input is accepted only while the block is idle; the bit count wraps modulo 2^64.
// The block buffer lives in a 16 x 32-bit RAM, filled big-endian word by word.
module sha256_byte_stream_hasher (
	input  logic      clk,
	input  logic      arst_n,
	shb_in_if.sink    in_ch,
	shb_out_if.source out_ch
);
	import shb_pkg::*;

	state_t      state_q, state_d;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [23:0] word_q;
	logic        fin_q;      // finish in progress
	logic        lend_q;     // length bytes written, last compression running
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic [31:0] chain_q [8];
	logic [31:0] v_q     [8];
	logic [31:0] sched_q [16];

	logic        in_xfer, out_xfer;
	logic        push;
	logic [7:0]  push_byte;
	logic        full;
	logic [5:0]  fill_nx;
	logic [7:0]  len_byte;
	logic        ram_we;
	logic [3:0]  ram_raddr;
	logic [31:0] ram_rdata;
	logic [31:0] w_calc, w_t, t1, t2, ch, mj;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign fill_nx  = fill_q + 6'd1;
	assign full     = push && (fill_q == LAST_BYTE);
	// length byte k (k = fill - 56) sits (7-k)*8 bits up
	assign len_byte = 8'(bits_q >> {~fill_q[2:0], 3'b000});

	// output decode
	always_comb begin
		in_ch.ready = 1'b0;
		out_ch.valid = 1'b0;
		push = 1'b0;
		push_byte = 8'h00;
		ram_raddr = 4'd0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				// ready is high here, so a valid byte is a transfer
				push = in_ch.valid;
				push_byte = (in_ch.operation == OP_ABSORB) ? in_ch.data_byte : PAD_MARK;
			end
			ST_PAD: begin
				push = 1'b1;
			end
			ST_LEN: begin
				push = 1'b1;
				push_byte = len_byte;
			end
			ST_LOAD: begin
				ram_raddr = 4'd0;
			end
			ST_ROUND: begin
				ram_raddr = 4'(rnd_q + 6'd1);
			end
			ST_FOLD: begin
			end
			ST_OUT: begin
				out_ch.valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (full) begin
						state_d = ST_LOAD;
					end else if (in_ch.operation == OP_FINISH) begin
						state_d = (fill_nx == LEN_START) ? ST_LEN : ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (full) begin
					state_d = ST_LOAD;
				end else if (fill_nx == LEN_START) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (full) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (lend_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_xfer && oidx_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// block buffer: one word written per four bytes
	assign ram_we = push && (fill_q[1:0] == 2'b11);

	shb_ram #(.WIDTH(32), .DEPTH(16)) u_block (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[5:2]),
		.wdata ({word_q, push_byte}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one round per cycle; first 16 words straight from the RAM
	assign w_calc = sched_q[0] + sml_sig0(sched_q[1]) + sched_q[9] + sml_sig1(sched_q[14]);
	assign w_t    = (rnd_q[5:4] == 2'b00) ? ram_rdata : w_calc;
	assign ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj     = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1     = v_q[7] + big_sig1(v_q[4]) + ch + round_k(rnd_q) + w_t;
	assign t2     = big_sig0(v_q[0]) + mj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
			fin_q   <= 1'b0;
			lend_q  <= 1'b0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= init_hash(3'(i));
			end
		end else begin
			state_q <= state_d;
			if (push) begin
				fill_q <= fill_nx;
			end
			if (in_xfer) begin
				if (in_ch.operation == OP_ABSORB) begin
					bits_q <= bits_q + 64'd8;
				end else begin
					fin_q <= 1'b1;
				end
			end
			if (state_q == ST_LEN && full) begin
				lend_q <= 1'b1;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_FOLD) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			if (out_xfer) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == LAST_WORD) begin
					// back to a fresh message
					bits_q <= '0;
					fin_q  <= 1'b0;
					lend_q <= 1'b0;
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= init_hash(3'(i));
					end
				end
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			word_q <= {word_q[15:0], push_byte};
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end
		if (state_q == ST_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= w_t;
		end
	end

	assign out_ch.digest_word = chain_q[oidx_q];
	assign out_ch.word_index  = oidx_q;
	assign out_ch.last_word   = (oidx_q == LAST_WORD);

	`include "sha256_byte_stream_hasher_assert.svh"

	// input and output never open together
	`SHB_ASSERT_NEVER(a_no_overlap, in_ch.ready && out_ch.valid, "input open during digest")
	// the 64th absorbed byte must start a compression
	`SHB_ASSERT_NEXT(a_full_blocks, in_xfer && in_ch.operation == OP_ABSORB && fill_q == LAST_BYTE, !in_ch.ready && fill_q == 6'd0, "full block did not compress")
	// after the last digest word the state is fresh
	`SHB_ASSERT_NEXT(a_fresh, out_xfer && out_ch.last_word, in_ch.ready && fill_q == 6'd0 && bits_q == 64'd0 && oidx_q == 3'd0, "state not cleared after digest")
endmodule
